FILE: hdl/indexed_min_heap_queue_macros.svh
// ----------------------------------------------------------------------------
// indexed_min_heap_queue_macros
// Assertion macros shared by the heap queue RTL. They compile to nothing when
// SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef INDEXED_MIN_HEAP_QUEUE_MACROS_SVH
`define INDEXED_MIN_HEAP_QUEUE_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define IMHQ_ASSERT_IMP(lbl, clk, rst, pre, post) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("heap queue check failed");
// next-cycle implication
`define IMHQ_ASSERT_NXT(lbl, clk, rst, pre, post) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("heap queue check failed");
`else
`define IMHQ_ASSERT_IMP(lbl, clk, rst, pre, post)
`define IMHQ_ASSERT_NXT(lbl, clk, rst, pre, post)
`endif

`endif

FILE: hdl/imhq_pkg.sv
// ----------------------------------------------------------------------------
// imhq_pkg
// Request and status codes, field widths and the heap entry type.
// ----------------------------------------------------------------------------
package imhq_pkg;

   localparam int VERTEX_W     = 6;
   localparam int NUM_VERTICES = 64;
   localparam int PRIO_W       = 32;
   localparam int TYPE_W       = 3;
   localparam int STATUS_W     = 3;
   localparam int COUNT_W      = 7;
   localparam int ENTRY_W      = VERTEX_W + PRIO_W;

   // request kinds
   localparam logic [TYPE_W-1:0] REQ_INSERT   = 3'd0;
   localparam logic [TYPE_W-1:0] REQ_EXTRACT  = 3'd1;
   localparam logic [TYPE_W-1:0] REQ_DECREASE = 3'd2;
   localparam logic [TYPE_W-1:0] REQ_CONTAINS = 3'd3;
   localparam logic [TYPE_W-1:0] REQ_GET_PRIO = 3'd4;

   // status codes
   localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
   localparam logic [STATUS_W-1:0] ST_FULL      = 3'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd2;
   localparam logic [STATUS_W-1:0] ST_ABSENT    = 3'd3;
   localparam logic [STATUS_W-1:0] ST_NOT_LOWER = 3'd4;
   localparam logic [STATUS_W-1:0] ST_DUP       = 3'd5;

   // one heap slot
   typedef struct packed {
      logic [VERTEX_W-1:0] vtx;
      logic [PRIO_W-1:0]   prio;
   } entry_type;

endpackage

FILE: hdl/indexed_min_heap_queue.sv
// ----------------------------------------------------------------------------
// indexed_min_heap_queue
// Indexed binary min-heap of (vertex, priority) pairs in a slot RAM, with a
// position RAM and per-vertex present bits.
// ----------------------------------------------------------------------------
// Sequencing: each request is decoded first; insert and decrease then sift the
//   entry up and extract sifts the last entry down one heap level at a time,
//   all through the single read port of the slot RAM.
// Throughput: one item at a time; the next beat is taken once the result
//   sits in the output register, which may still be waiting on rsp_stall.
// Reset: synchronous; empties the heap and clears all present bits at once.
// ----------------------------------------------------------------------------
`include "indexed_min_heap_queue_macros.svh"

module indexed_min_heap_queue #(
   parameter int CAPACITY = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_type,
   input  logic [5:0]  req_vertex_id,
   input  logic [31:0] req_new_priority,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_status,
   output logic [5:0]  rsp_out_vertex,
   output logic [31:0] rsp_out_priority,
   output logic        rsp_is_present,
   output logic [6:0]  rsp_entry_count
);

   localparam int SW = $clog2(CAPACITY);
   localparam int FW = $clog2(CAPACITY + 1);
   localparam int CW = SW + 2;

   localparam logic [3:0] S_IDLE    = 4'd0;
   localparam logic [3:0] S_DECODE  = 4'd1;
   localparam logic [3:0] S_SU_RD   = 4'd2;
   localparam logic [3:0] S_SU_CMP  = 4'd3;
   localparam logic [3:0] S_DK_CHK  = 4'd4;
   localparam logic [3:0] S_GP_RD   = 4'd5;
   localparam logic [3:0] S_EX_ROOT = 4'd6;
   localparam logic [3:0] S_EX_LAST = 4'd7;
   localparam logic [3:0] S_SD_RL   = 4'd8;
   localparam logic [3:0] S_SD_RR   = 4'd9;
   localparam logic [3:0] S_SD_CMP  = 4'd10;
   localparam logic [3:0] S_FIN     = 4'd11;

   logic [3:0]  state_ff, state_in;
   logic [FW-1:0] fill_ff, fill_in;
   logic [imhq_pkg::NUM_VERTICES-1:0] vld_ff, vld_in;
   logic [SW-1:0] idx_ff, idx_in;
   imhq_pkg::entry_type mv_ff, mv_in;
   imhq_pkg::entry_type lft_ff, lft_in;
   logic [imhq_pkg::TYPE_W-1:0]   cur_type_ff, cur_type_in;
   logic [imhq_pkg::VERTEX_W-1:0] cur_v_ff, cur_v_in;
   logic [imhq_pkg::PRIO_W-1:0]   cur_p_ff, cur_p_in;
   logic [imhq_pkg::STATUS_W-1:0] st_ff, st_in;
   logic [imhq_pkg::VERTEX_W-1:0] ov_ff, ov_in;
   logic [imhq_pkg::PRIO_W-1:0]   op_ff, op_in;

   logic                            rsp_valid_ff, rsp_valid_in;
   logic [imhq_pkg::STATUS_W-1:0]   rsp_st_ff, rsp_st_in;
   logic [imhq_pkg::VERTEX_W-1:0]   rsp_ov_ff, rsp_ov_in;
   logic [imhq_pkg::PRIO_W-1:0]     rsp_op_ff, rsp_op_in;
   logic                            rsp_pr_ff, rsp_pr_in;
   logic [imhq_pkg::COUNT_W-1:0]    rsp_cnt_ff, rsp_cnt_in;

   // RAM ports
   logic          hp_re, hp_we, ps_re, ps_we;
   logic [SW-1:0] hp_ra, hp_wa, ps_wd, ps_rd;
   logic [imhq_pkg::VERTEX_W-1:0] ps_ra, ps_wa;
   imhq_pkg::entry_type hp_wd, hp_rd;
   logic [imhq_pkg::ENTRY_W-1:0] hp_rd_raw;

   logic          accept, out_free, load_rsp;
   logic [CW-1:0] lc, rc, fill_x;
   logic          l_ok, r_ok;
   logic [SW-1:0] parent;
   logic [FW-1:0] last;

   imhq_ram #(.WIDTH(imhq_pkg::ENTRY_W), .DEPTH(CAPACITY)) u_slot_ram (
      .clock   (clock),
      .wr_en   (hp_we),
      .wr_addr (hp_wa),
      .wr_data (hp_wd),
      .rd_en   (hp_re),
      .rd_addr (hp_ra),
      .rd_data (hp_rd_raw)
   );

   imhq_ram #(.WIDTH(SW), .DEPTH(imhq_pkg::NUM_VERTICES)) u_pos_ram (
      .clock   (clock),
      .wr_en   (ps_we),
      .wr_addr (ps_wa),
      .wr_data (ps_wd),
      .rd_en   (ps_re),
      .rd_addr (ps_ra),
      .rd_data (ps_rd)
   );

   assign hp_rd = imhq_pkg::entry_type'(hp_rd_raw);

   // handshake
   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && (state_ff == S_IDLE);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign load_rsp  = (state_ff == S_FIN) && out_free;

   // heap geometry
   assign lc     = {1'b0, idx_ff, 1'b1};
   assign rc     = lc + CW'(1);
   assign fill_x = CW'(fill_ff);
   assign l_ok   = lc < fill_x;
   assign r_ok   = rc < fill_x;
   assign parent = SW'((idx_ff - SW'(1)) >> 1);
   assign last   = fill_ff - FW'(1);

   // sequencer
   always_comb begin
      logic [1:0]            bsel;
      logic [imhq_pkg::PRIO_W-1:0] bp;
      state_in    = state_ff;
      fill_in     = fill_ff;
      vld_in      = vld_ff;
      idx_in      = idx_ff;
      mv_in       = mv_ff;
      lft_in      = lft_ff;
      cur_type_in = cur_type_ff;
      cur_v_in    = cur_v_ff;
      cur_p_in    = cur_p_ff;
      st_in       = st_ff;
      ov_in       = ov_ff;
      op_in       = op_ff;
      hp_re       = 1'b0;
      hp_ra       = '0;
      hp_we       = 1'b0;
      hp_wa       = idx_ff;
      hp_wd       = mv_ff;
      ps_re       = accept;
      ps_ra       = req_vertex_id;
      ps_we       = 1'b0;
      ps_wa       = mv_ff.vtx;
      ps_wd       = idx_ff;
      bsel        = 2'd0;
      bp          = mv_ff.prio;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cur_type_in = req_type;
               cur_v_in    = req_vertex_id;
               cur_p_in    = req_new_priority;
               st_in       = imhq_pkg::ST_OK;
               ov_in       = '0;
               op_in       = '0;
               state_in    = S_DECODE;
            end
         end
         S_DECODE: begin
            state_in = S_FIN;
            case (cur_type_ff)
               imhq_pkg::REQ_INSERT: begin
                  if (fill_ff == FW'(CAPACITY)) begin
                     st_in = imhq_pkg::ST_FULL;
                  end else if (vld_ff[cur_v_ff]) begin
                     st_in = imhq_pkg::ST_DUP;
                  end else begin
                     vld_in[cur_v_ff] = 1'b1;
                     fill_in  = fill_ff + FW'(1);
                     idx_in   = fill_ff[SW-1:0];
                     mv_in    = '{vtx: cur_v_ff, prio: cur_p_ff};
                     state_in = S_SU_RD;
                  end
               end
               imhq_pkg::REQ_EXTRACT: begin
                  if (fill_ff == '0) begin
                     st_in = imhq_pkg::ST_EMPTY;
                  end else begin
                     hp_re    = 1'b1;
                     hp_ra    = '0;
                     state_in = S_EX_ROOT;
                  end
               end
               imhq_pkg::REQ_DECREASE: begin
                  if (!vld_ff[cur_v_ff]) begin
                     st_in = imhq_pkg::ST_ABSENT;
                  end else begin
                     hp_re    = 1'b1;
                     hp_ra    = ps_rd;
                     idx_in   = ps_rd;
                     state_in = S_DK_CHK;
                  end
               end
               imhq_pkg::REQ_GET_PRIO: begin
                  if (!vld_ff[cur_v_ff]) begin
                     st_in = imhq_pkg::ST_ABSENT;
                  end else begin
                     hp_re    = 1'b1;
                     hp_ra    = ps_rd;
                     state_in = S_GP_RD;
                  end
               end
               default: begin
                  state_in = S_FIN;
               end
            endcase
         end
         S_DK_CHK: begin
            if ($signed(hp_rd.prio) <= $signed(cur_p_ff)) begin
               st_in    = imhq_pkg::ST_NOT_LOWER;
               state_in = S_FIN;
            end else begin
               mv_in    = '{vtx: cur_v_ff, prio: cur_p_ff};
               state_in = S_SU_RD;
            end
         end
         S_GP_RD: begin
            op_in    = hp_rd.prio;
            state_in = S_FIN;
         end
         // sift up: fetch parent, or settle at the root
         S_SU_RD: begin
            if (idx_ff == '0) begin
               hp_we    = 1'b1;
               ps_we    = 1'b1;
               state_in = S_FIN;
            end else begin
               hp_re    = 1'b1;
               hp_ra    = parent;
               state_in = S_SU_CMP;
            end
         end
         S_SU_CMP: begin
            if ($signed(hp_rd.prio) > $signed(mv_ff.prio)) begin
               // parent moves down into the hole
               hp_we    = 1'b1;
               hp_wd    = hp_rd;
               ps_we    = 1'b1;
               ps_wa    = hp_rd.vtx;
               idx_in   = parent;
               state_in = S_SU_RD;
            end else begin
               hp_we    = 1'b1;
               ps_we    = 1'b1;
               state_in = S_FIN;
            end
         end
         S_EX_ROOT: begin
            ov_in              = hp_rd.vtx;
            op_in              = hp_rd.prio;
            vld_in[hp_rd.vtx]  = 1'b0;
            fill_in            = last;
            if (last == '0) begin
               state_in = S_FIN;
            end else begin
               hp_re    = 1'b1;
               hp_ra    = last[SW-1:0];
               state_in = S_EX_LAST;
            end
         end
         S_EX_LAST: begin
            mv_in    = hp_rd;
            idx_in   = '0;
            state_in = S_SD_RL;
         end
         // sift down: left child, right child, then compare
         S_SD_RL: begin
            if (!l_ok) begin
               hp_we    = 1'b1;
               ps_we    = 1'b1;
               state_in = S_FIN;
            end else begin
               hp_re    = 1'b1;
               hp_ra    = lc[SW-1:0];
               state_in = S_SD_RR;
            end
         end
         S_SD_RR: begin
            lft_in   = hp_rd;
            hp_re    = r_ok;
            hp_ra    = rc[SW-1:0];
            state_in = S_SD_CMP;
         end
         S_SD_CMP: begin
            if ($signed(lft_ff.prio) < $signed(bp)) begin
               bsel = 2'd1;
               bp   = lft_ff.prio;
            end
            if (r_ok && ($signed(hp_rd.prio) < $signed(bp))) begin
               bsel = 2'd2;
            end
            hp_we = 1'b1;
            ps_we = 1'b1;
            if (bsel == 2'd0) begin
               state_in = S_FIN;
            end else if (bsel == 2'd1) begin
               hp_wd    = lft_ff;
               ps_wa    = lft_ff.vtx;
               idx_in   = lc[SW-1:0];
               state_in = S_SD_RL;
            end else begin
               hp_wd    = hp_rd;
               ps_wa    = hp_rd.vtx;
               idx_in   = rc[SW-1:0];
               state_in = S_SD_RL;
            end
         end
         S_FIN: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // output register
   always_comb begin
      rsp_valid_in = (rsp_valid_ff && rsp_stall) || load_rsp;
      rsp_st_in    = rsp_st_ff;
      rsp_ov_in    = rsp_ov_ff;
      rsp_op_in    = rsp_op_ff;
      rsp_pr_in    = rsp_pr_ff;
      rsp_cnt_in   = rsp_cnt_ff;
      if (load_rsp) begin
         rsp_st_in  = st_ff;
         rsp_ov_in  = ov_ff;
         rsp_op_in  = op_ff;
         rsp_pr_in  = vld_ff[cur_v_ff];
         rsp_cnt_in = imhq_pkg::COUNT_W'(fill_ff);
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         fill_ff      <= '0;
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         vld_ff       <= vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      mv_ff       <= mv_in;
      lft_ff      <= lft_in;
      cur_type_ff <= cur_type_in;
      cur_v_ff    <= cur_v_in;
      cur_p_ff    <= cur_p_in;
      st_ff       <= st_in;
      ov_ff       <= ov_in;
      op_ff       <= op_in;
      rsp_st_ff   <= rsp_st_in;
      rsp_ov_ff   <= rsp_ov_in;
      rsp_op_ff   <= rsp_op_in;
      rsp_pr_ff   <= rsp_pr_in;
      rsp_cnt_ff  <= rsp_cnt_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_st_ff;
   assign rsp_out_vertex   = rsp_ov_ff;
   assign rsp_out_priority = rsp_op_ff;
   assign rsp_is_present   = rsp_pr_ff;
   assign rsp_entry_count  = rsp_cnt_ff;

   `IMHQ_ASSERT_IMP(a_fill_bound, clock, reset, 1'b1, fill_ff <= FW'(CAPACITY))
   `IMHQ_ASSERT_IMP(a_root_nonempty, clock, reset, state_ff == S_EX_ROOT, fill_ff != '0)
   `IMHQ_ASSERT_NXT(a_result_loaded, clock, reset, load_rsp, rsp_valid_ff)
   `IMHQ_ASSERT_IMP(a_sift_in_range, clock, reset, state_ff == S_SD_CMP, l_ok)

endmodule

FILE: hdl/imhq_ram.sv
// ----------------------------------------------------------------------------
// imhq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module imhq_ram #(
   parameter int WIDTH = 38,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

FILE: tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the indexed min-heap queue: a queued driver, a
// monitor that compares every response beat with a behavioral heap predictor,
// random idling on both channels and a long response hold-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

   localparam int CAP       = 64;
   localparam int WDOG_MAX  = 20000;

   typedef struct {
      logic [2:0]  kind;
      logic [5:0]  vtx;
      logic [31:0] prio;
   } heap_req_t;

   typedef struct {
      logic [2:0]  status;
      logic [5:0]  vtx;
      logic [31:0] prio;
      logic        present;
      logic [6:0]  count;
   } heap_rsp_t;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [2:0]  req_type = '0;
   logic [5:0]  req_vertex_id = '0;
   logic [31:0] req_new_priority = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [2:0]  rsp_status;
   logic [5:0]  rsp_out_vertex;
   logic [31:0] rsp_out_priority;
   logic        rsp_is_present;
   logic [6:0]  rsp_entry_count;

   indexed_min_heap_queue #(.CAPACITY(CAP)) u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_type(req_type),
      .req_vertex_id(req_vertex_id), .req_new_priority(req_new_priority),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_status(rsp_status),
      .rsp_out_vertex(rsp_out_vertex), .rsp_out_priority(rsp_out_priority),
      .rsp_is_present(rsp_is_present), .rsp_entry_count(rsp_entry_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // predictor state
   logic [5:0]         hv [CAP];
   logic signed [31:0] hp [CAP];
   int                 pos [64];
   bit                 here [64];
   int                 fill = 0;

   heap_req_t pending_reqs[$];
   heap_rsp_t expected_rsps[$];
   int        mismatches = 0;
   int        wdog = 0;
   bit        req_taken = 0;
   bit        sender_hold = 0;
   int        hold_cycles = 0;
   int        req_gap = 0;
   int        rsp_gap = 0;

   function automatic void swap_entries(int a, int b);
      logic [5:0]         tv;
      logic signed [31:0] tp;
      tv = hv[a]; tp = hp[a];
      hv[a] = hv[b]; hp[a] = hp[b];
      hv[b] = tv; hp[b] = tp;
      pos[hv[a]] = a;
      pos[hv[b]] = b;
   endfunction

   function automatic void bubble_up(int i);
      int par;
      while (i > 0) begin
         par = (i - 1) / 2;
         if (!(hp[par] > hp[i])) break;
         swap_entries(i, par);
         i = par;
      end
   endfunction

   function automatic void bubble_down(int i);
      int best, l, r;
      while (i < fill) begin
         best = i; l = 2 * i + 1; r = 2 * i + 2;
         if (l < fill && hp[l] < hp[best]) best = l;
         if (r < fill && hp[r] < hp[best]) best = r;
         if (best == i) break;
         swap_entries(i, best);
         i = best;
      end
   endfunction

   // apply one request to the heap model and return its response
   function automatic heap_rsp_t heap_apply(heap_req_t rq);
      heap_rsp_t          rs;
      logic signed [31:0] p;
      int                 v;
      p = rq.prio;
      v = rq.vtx;
      rs.status = imhq_pkg::ST_OK; rs.vtx = '0; rs.prio = '0;
      case (rq.kind)
         imhq_pkg::REQ_INSERT: begin
            if (fill >= CAP) rs.status = imhq_pkg::ST_FULL;
            else if (here[v]) rs.status = imhq_pkg::ST_DUP;
            else begin
               hv[fill] = rq.vtx; hp[fill] = p; pos[v] = fill; here[v] = 1;
               fill++;
               bubble_up(fill - 1);
            end
         end
         imhq_pkg::REQ_EXTRACT: begin
            if (fill == 0) rs.status = imhq_pkg::ST_EMPTY;
            else begin
               rs.vtx = hv[0]; rs.prio = hp[0];
               here[hv[0]] = 0;
               fill--;
               if (fill > 0) begin
                  hv[0] = hv[fill]; hp[0] = hp[fill]; pos[hv[0]] = 0;
                  bubble_down(0);
               end
            end
         end
         imhq_pkg::REQ_DECREASE: begin
            if (!here[v]) rs.status = imhq_pkg::ST_ABSENT;
            else if (hp[pos[v]] <= p) rs.status = imhq_pkg::ST_NOT_LOWER;
            else begin
               hp[pos[v]] = p;
               bubble_up(pos[v]);
            end
         end
         imhq_pkg::REQ_GET_PRIO: begin
            if (!here[v]) rs.status = imhq_pkg::ST_ABSENT;
            else rs.prio = hp[pos[v]];
         end
         default: ;
      endcase
      rs.present = here[v];
      rs.count = 7'(fill);
      return rs;
   endfunction

   function automatic logic [31:0] rand_prio();
      case ($urandom_range(0, 5))
         0: return 32'h8000_0000 + $urandom_range(0, 3);
         1: return 32'h7FFF_FFFF - $urandom_range(0, 3);
         2: return 32'($urandom_range(0, 20)) - 32'd10;
         default: return $urandom;
      endcase
   endfunction

   task automatic push_req(logic [2:0] k, logic [5:0] v, logic [31:0] p);
      heap_req_t rq;
      rq.kind = k; rq.vtx = v; rq.prio = p;
      pending_reqs.push_back(rq);
   endtask

   function automatic int short_gap();
      if ($urandom_range(0, 39) == 0) return $urandom_range(10, 40);
      if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
      return 0;
   endfunction

   // driver: one beat per handshake, changes on the falling edge
   always @(negedge clock) begin
      if (!reset) begin
         // a waiting beat stays put until the monitor sees it taken
         if (!req_valid || req_taken) begin
            if (req_taken) begin
               req_taken = 0;
               req_gap = short_gap();
            end
            if (req_gap > 0 || sender_hold || pending_reqs.size() == 0) begin
               req_valid <= 1'b0;
               if (req_gap > 0) req_gap--;
            end else begin
               heap_req_t rq;
               rq = pending_reqs.pop_front();
               req_valid <= 1'b1;
               req_type <= rq.kind;
               req_vertex_id <= rq.vtx;
               req_new_priority <= rq.prio;
            end
         end
      end
   end

   // receiver side idling and long hold-off
   always @(negedge clock) begin
      if (!reset) begin
         if (hold_cycles > 0) begin
            rsp_stall <= 1'b1;
            hold_cycles--;
         end else if (rsp_gap > 0) begin
            rsp_stall <= 1'b1;
            rsp_gap--;
         end else begin
            rsp_stall <= 1'b0;
            rsp_gap = short_gap();
         end
      end
   end

   // monitor: sample at the rising edge
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) wdog = 0;
         else wdog++;
         if (wdog >= WDOG_MAX) begin
            $display("** indexed_min_heap_queue: FAILED **");
            $finish;
         end
         if (req_valid && !req_stall) begin
            expected_rsps.push_back(heap_apply('{req_type, req_vertex_id,
                                                 req_new_priority}));
            req_taken = 1;
         end
         if (rsp_valid && !rsp_stall) begin
            heap_rsp_t ex;
            if (expected_rsps.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected response beat");
            end else begin
               ex = expected_rsps.pop_front();
               if (ex.status !== rsp_status || ex.vtx !== rsp_out_vertex ||
                   ex.prio !== rsp_out_priority || ex.present !== rsp_is_present
                   || ex.count !== rsp_entry_count) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: exp st%0d v%0d p%0d pr%0d n%0d got st%0d v%0d p%0d pr%0d n%0d",
                              ex.status, ex.vtx, $signed(ex.prio), ex.present, ex.count,
                              rsp_status, rsp_out_vertex, $signed(rsp_out_priority),
                              rsp_is_present, rsp_entry_count);
               end
            end
         end
      end
   end

   // stimulus
   initial begin
      int n;
      for (int k = 0; k < 64; k++) here[k] = 0;
      repeat (5) @(posedge clock);
      @(negedge clock) reset = 1'b0;

      // directed: empty cases, extremes, all request kinds
      push_req(imhq_pkg::REQ_EXTRACT, 6'd0, 32'd0);
      push_req(imhq_pkg::REQ_DECREASE, 6'd5, 32'd1);
      push_req(imhq_pkg::REQ_GET_PRIO, 6'd5, 32'd0);
      push_req(imhq_pkg::REQ_CONTAINS, 6'd5, 32'd0);
      push_req(imhq_pkg::REQ_INSERT, 6'd63, 32'h7FFF_FFFF);
      push_req(imhq_pkg::REQ_INSERT, 6'd0, 32'h8000_0000);
      push_req(imhq_pkg::REQ_INSERT, 6'd21, 32'd5);
      push_req(imhq_pkg::REQ_INSERT, 6'd42, 32'd5);
      push_req(imhq_pkg::REQ_INSERT, 6'd21, 32'd9);
      push_req(imhq_pkg::REQ_DECREASE, 6'd21, 32'd5);
      push_req(imhq_pkg::REQ_DECREASE, 6'd21, 32'd6);
      push_req(imhq_pkg::REQ_DECREASE, 6'd63, 32'hFFFF_FFFF);
      push_req(imhq_pkg::REQ_GET_PRIO, 6'd63, 32'd0);
      push_req(3'd5, 6'd63, 32'd0);
      push_req(3'd6, 6'd1, 32'hFFFF_FFFF);
      push_req(3'd7, 6'd0, 32'd0);
      for (int k = 0; k < 5; k++) push_req(imhq_pkg::REQ_EXTRACT, 6'd0, 32'd0);

      // fill to capacity, hit full, then drain; receiver held off meanwhile
      for (int k = 0; k < 64; k++) push_req(imhq_pkg::REQ_INSERT, 6'(k), rand_prio());
      push_req(imhq_pkg::REQ_INSERT, 6'd7, 32'd0);
      hold_cycles = 300;
      wait (pending_reqs.size() == 0 && !req_valid);
      for (int k = 0; k < 65; k++) push_req(imhq_pkg::REQ_EXTRACT, 6'd0, 32'd0);

      // pause the sender until everything has come back
      wait (pending_reqs.size() == 0 && !req_valid);
      sender_hold = 1;
      wait (expected_rsps.size() == 0);
      sender_hold = 0;

      // random: mostly build-up and drain runs with lookups mixed in
      n = 0;
      while (n < 1400) begin
         int bias;
         bias = $urandom_range(0, 3);
         repeat ($urandom_range(10, 80)) begin
            int r;
            logic [2:0] k;
            r = $urandom_range(0, 99);
            if (r < (bias == 0 ? 55 : 30)) k = imhq_pkg::REQ_INSERT;
            else if (r < 55) k = imhq_pkg::REQ_EXTRACT;
            else if (r < 75) k = imhq_pkg::REQ_DECREASE;
            else if (r < 85) k = imhq_pkg::REQ_CONTAINS;
            else if (r < 97) k = imhq_pkg::REQ_GET_PRIO;
            else k = 3'($urandom_range(5, 7));
            if (bias == 1 && r < 55) k = imhq_pkg::REQ_EXTRACT;
            push_req(k, 6'($urandom_range(0, 63)), rand_prio());
            n++;
         end
         wait (pending_reqs.size() < 20);
      end
      wait (pending_reqs.size() == 0 && !req_valid);
      wait (expected_rsps.size() == 0);
      repeat (50) @(posedge clock);
      if (mismatches == 0 && expected_rsps.size() == 0)
         $display("** indexed_min_heap_queue: PASSED **");
      else
         $display("** indexed_min_heap_queue: FAILED **");
      $finish;
   end

endmodule
